@@ design/tepu_pkg.sv @@
// Shared types and constants for the drift-chamber edge-pair unpacker.
// No dependencies; every other design file except tepu_fifo imports this package.
`default_nettype none

package tepu_pkg;

    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NIBBLE_COUNT  = 2'd2;

    localparam logic [9:0] MIN_WIDTH_RST     = 10'd20;
    localparam logic [7:0] CHANNEL_COUNT_RST = 8'd128;
    localparam logic [6:0] NIBBLE_COUNT_RST  = 7'd64;

    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_LEAD  = 2'd1,
        EDGE_TRAIL = 2'd2
    } edge_state_t;

    typedef struct packed {
        logic [31:0] word;
        logic        arm;
        logic        side;
        logic [7:0]  keystone;
        logic [3:0]  pair;
        logic        event_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0] hit_id;
        logic        out_arm;
        logic        out_side;
        logic [7:0]  out_keystone;
        logic [3:0]  out_pair;
        logic [6:0]  out_channel;
        logic        edge_kind;
        logic [9:0]  edge_time;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic       arm;
        logic       side;
        logic [7:0] keystone;
        logic [3:0] pair;
        logic [6:0] channel;
    } address_t;

    typedef struct packed {
        address_t    addr;
        logic [15:0] hit_base;
        logic        two_pairs;
        logic [9:0]  lead0;
        logic [9:0]  trail0;
        logic [9:0]  lead1;
        logic [9:0]  trail1;
    } pair_job_t;

endpackage

`default_nettype wire

@@ design/tepu_fifo.sv @@
// Small register queue between the classifier and the result sequencer.
// Generic width and depth; no package dependency.
`default_nettype none

module tepu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/tepu_front.sv @@
// Front end: configuration registers, word filtering, nibble decoding and edge pairing.
// Depends on tepu_pkg; emits one pair job per word that yields at least one pair.
`default_nettype none

module tepu_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire tepu_pkg::in_item_t                 item,
    input  wire logic                               stall,
    input  wire logic                               wr_en,
    input  wire logic [tepu_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [tepu_pkg::CFG_DATA_W-1:0]    wr_data,
    output logic                                    job_push,
    output tepu_pkg::pair_job_t                     job
);

    import tepu_pkg::*;

    logic [9:0]  min_width_reg, min_width_next;
    logic [7:0]  channel_count_reg, channel_count_next;
    logic [6:0]  nibble_count_reg, nibble_count_next;
    address_t    prev_addr_reg, prev_addr_next;
    edge_state_t prev_state_reg, prev_state_next;
    logic [9:0]  lead_time_reg, lead_time_next;
    logic [15:0] hit_counter_reg, hit_counter_next;

    logic        accept;
    logic        keep;
    address_t    addr;
    address_t    pa;
    edge_state_t st;
    logic [9:0]  lt;
    logic [15:0] cnt;
    logic [1:0]  npair;
    logic [5:0]  nib;
    logic [4:0]  v;
    logic [9:0]  tt;
    logic [11:0] w;
    logic [9:0]  lead0, trail0, lead1, trail1;

    assign accept = push && !stall;

    always_comb
    begin
        min_width_next     = min_width_reg;
        channel_count_next = channel_count_reg;
        nibble_count_next  = nibble_count_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_MIN_WIDTH:     min_width_next     = wr_data;
                REG_CHANNEL_COUNT: channel_count_next = wr_data[7:0];
                REG_NIBBLE_COUNT:  nibble_count_next  = wr_data[6:0];
                default:           ;
            endcase
        end
    end

    // walk the four nibbles in order, carrying the pairing state
    always_comb
    begin
        st     = item.event_start ? EDGE_NONE : prev_state_reg;
        lt     = item.event_start ? '0 : lead_time_reg;
        pa     = item.event_start ? '0 : prev_addr_reg;
        cnt    = item.event_start ? '0 : hit_counter_reg;
        keep   = !item.word[31] && (item.word[19:0] != '0)
                 && ({1'b0, item.word[30:24]} < channel_count_reg);
        addr.arm      = item.arm;
        addr.side     = item.side;
        addr.keystone = item.keystone;
        addr.pair     = item.pair;
        addr.channel  = item.word[30:24];
        npair  = '0;
        lead0  = '0;
        trail0 = '0;
        lead1  = '0;
        trail1 = '0;
        nib    = '0;
        v      = '0;
        tt     = '0;
        w      = '0;
        if (keep && (addr != pa))
        begin
            st = EDGE_NONE;
        end
        for (int m = 0; m < 4; m++)
        begin
            nib = {item.word[23:20], 2'(m)};
            v   = item.word[m*5 +: 5];
            if (keep && ({1'b0, nib} < nibble_count_reg))
            begin
                if (v[4])
                begin
                    lt = {nib, v[3:0]};
                    pa = addr;
                    st = EDGE_LEAD;
                end
                else if (v[3])
                begin
                    tt = {nib, v[2:0], 1'b0};
                    w  = {2'b00, tt} - {2'b00, lt};
                    if (st == EDGE_LEAD && $signed(w) > $signed({2'b00, min_width_reg}))
                    begin
                        if (npair == 2'd0)
                        begin
                            lead0  = lt;
                            trail0 = tt;
                        end
                        else
                        begin
                            lead1  = lt;
                            trail1 = tt;
                        end
                        npair = npair + 1'b1;
                    end
                    pa = addr;
                    st = EDGE_TRAIL;
                end
            end
        end
    end

    always_comb
    begin
        prev_addr_next   = prev_addr_reg;
        prev_state_next  = prev_state_reg;
        lead_time_next   = lead_time_reg;
        hit_counter_next = hit_counter_reg;
        if (accept)
        begin
            prev_addr_next   = pa;
            prev_state_next  = st;
            lead_time_next   = lt;
            hit_counter_next = cnt + {13'd0, npair, 1'b0};
        end
    end

    assign job_push      = accept && (npair != 2'd0);
    assign job.addr      = addr;
    assign job.hit_base  = cnt;
    assign job.two_pairs = npair[1];
    assign job.lead0     = lead0;
    assign job.trail0    = trail0;
    assign job.lead1     = lead1;
    assign job.trail1    = trail1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg     <= MIN_WIDTH_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
            nibble_count_reg  <= NIBBLE_COUNT_RST;
            prev_addr_reg     <= '0;
            prev_state_reg    <= EDGE_NONE;
            lead_time_reg     <= '0;
            hit_counter_reg   <= '0;
        end
        else
        begin
            min_width_reg     <= min_width_next;
            channel_count_reg <= channel_count_next;
            nibble_count_reg  <= nibble_count_next;
            prev_addr_reg     <= prev_addr_next;
            prev_state_reg    <= prev_state_next;
            lead_time_reg     <= lead_time_next;
            hit_counter_reg   <= hit_counter_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tepu_back.sv @@
// Back end: expands each pair job into leading and trailing results, one per cycle while pop frees the output.
// Depends on tepu_pkg; holds the result in an output register.
`default_nettype none

module tepu_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tepu_pkg::pair_job_t   job,
    input  wire logic                  job_empty,
    output logic                       job_pop,
    output logic                       empty,
    input  wire logic                  pop,
    output tepu_pkg::out_item_t        result
);

    import tepu_pkg::*;

    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       advance;
    logic       final_step;

    assign advance    = !out_valid_reg || pop;
    assign final_step = job.two_pairs ? (step_reg == 2'd3) : (step_reg == 2'd1);
    assign job_pop    = advance && !job_empty && final_step;
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    always_comb
    begin
        out_next              = out_reg;
        out_valid_next        = out_valid_reg;
        step_next             = step_reg;
        if (advance)
        begin
            out_valid_next        = !job_empty;
            out_next.hit_id       = job.hit_base + {14'd0, step_reg};
            out_next.out_arm      = job.addr.arm;
            out_next.out_side     = job.addr.side;
            out_next.out_keystone = job.addr.keystone;
            out_next.out_pair     = job.addr.pair;
            out_next.out_channel  = job.addr.channel;
            out_next.edge_kind    = step_reg[0];
            case (step_reg)
                2'd0:    out_next.edge_time = job.lead0;
                2'd1:    out_next.edge_time = job.trail0;
                2'd2:    out_next.edge_time = job.lead1;
                default: out_next.edge_time = job.trail1;
            endcase
            out_next.last = final_step;
            if (!job_empty)
            begin
                step_next = final_step ? 2'd0 : step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ design/tdc_edge_pair_unpacker.sv @@
// Top level of the drift-chamber edge-pair unpacker.
// Depends on tepu_pkg, tepu_front, tepu_fifo and tepu_back.
//
// A readout word is taken in every cycle while full is low; filtering, nibble
// decoding and edge pairing finish in the cycle of acceptance. A word that yields
// n leading/trailing pairs (n up to 2) leaves a job in a QUEUE_DEPTH-entry queue and
// is then expanded into 2n results on the result port, one result per cycle while pop
// keeps the output register free. Each word's results pass through the queue and the
// output register. full is raised while the queue is full.
`default_nettype none

module tdc_edge_pair_unpacker #(
    parameter int QUEUE_DEPTH = tepu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire tepu_pkg::in_item_t                 item,
    output logic                                    empty,
    input  wire logic                               pop,
    output tepu_pkg::out_item_t                     result,
    input  wire logic                               wr_en,
    input  wire logic [tepu_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [tepu_pkg::CFG_DATA_W-1:0]    wr_data
);

    import tepu_pkg::*;

    pair_job_t job_in;
    pair_job_t job_out;
    logic      job_push;
    logic      job_pop;
    logic      job_empty;

    tepu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .stall    (full),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .job_push (job_push),
        .job      (job_in)
    );

    tepu_fifo #(
        .WIDTH ($bits(pair_job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (full),
        .empty   (job_empty)
    );

    tepu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ verif/tb_tdc_edge_pair_unpacker.sv @@
// Testbench for tdc_edge_pair_unpacker: a directed table, then random phases
// under several register settings, all results checked field by field.
// Depends on tepu_pkg and the unpacker RTL.

module tb_tdc_edge_pair_unpacker;

    import tepu_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam logic KIND_LEAD  = 1'b0;
    localparam logic KIND_TRAIL = 1'b1;
    localparam int   PREDICTED  = -1;
    localparam int   PHASES     = 8;

    typedef struct {
        in_item_t  stim;
        int        typed_count;
        out_item_t first;
        out_item_t second;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    in_item_t               item = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    out_item_t              result;
    logic                   wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0]  wr_data = '0;

    logic [9:0]  width_floor = MIN_WIDTH_RST;
    logic [7:0]  chan_limit = CHANNEL_COUNT_RST;
    logic [6:0]  nib_limit = NIBBLE_COUNT_RST;
    address_t    last_addr = '0;
    edge_state_t pairing = EDGE_NONE;
    logic [9:0]  held_lead = '0;
    logic [15:0] hit_seq = '0;

    out_item_t   hits_due[$];
    out_item_t   word_hits[$];
    plan_row_t   plan[$];
    address_t    pool[4];
    out_item_t   want;
    bit          calm = 1'b0;
    int          mismatches = 0;

    int phase_mw  [PHASES] = '{20, 0,   1023, 7, 15, 20, 20, 0};
    int phase_cc  [PHASES] = '{128, 128, 255, 1, 64, 0,  128, 0};
    int phase_nc  [PHASES] = '{64, 64,  127, 1, 40, 64, 0,  0};
    int phase_len [PHASES] = '{40, 50,  20,  20, 50, 10, 10, 50};

    tdc_edge_pair_unpacker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(0, 99) < 7);
    endfunction

    function automatic out_item_t hit(input logic [15:0] id, input logic arm, input logic side,
                                      input logic [7:0] ks, input logic [3:0] pr,
                                      input logic [6:0] ch, input logic kind,
                                      input logic [9:0] t, input logic fin);
        return '{id, arm, side, ks, pr, ch, kind, t, fin};
    endfunction

    function automatic plan_row_t edge_row(input logic [31:0] word, input logic arm,
                                           input logic side, input logic [7:0] ks,
                                           input logic [3:0] pr, input logic es,
                                           input int typed, input out_item_t a,
                                           input out_item_t b);
        plan_row_t r;
        r.stim = '{word, arm, side, ks, pr, es};
        r.typed_count = typed;
        r.first = a;
        r.second = b;
        return r;
    endfunction

    task automatic emit_edge(input address_t a, input logic kind, input logic [9:0] t);
        word_hits.push_back('{hit_seq, a.arm, a.side, a.keystone, a.pair, a.channel,
                              kind, t, 1'b0});
        hit_seq = hit_seq + 16'd1;
    endtask

    // Work out the edges that one accepted word yields, advancing the pairing state.
    task automatic pair_edges(input in_item_t it);
        address_t   a;
        logic [4:0] v;
        logic [5:0] nib;
        logic [9:0] tt;
        int         m;
        int         width;
        word_hits.delete();
        if (it.event_start)
        begin
            last_addr = '0;
            pairing   = EDGE_NONE;
            held_lead = '0;
            hit_seq   = '0;
        end
        if (it.word[31] || it.word[19:0] == 20'd0 || {1'b0, it.word[30:24]} >= chan_limit)
            return;
        a = '{it.arm, it.side, it.keystone, it.pair, it.word[30:24]};
        if (a != last_addr)
            pairing = EDGE_NONE;
        for (m = 0; m < 4; m++)
        begin
            nib = {it.word[23:20], 2'(m)};
            v = it.word[m*5 +: 5];
            if ({1'b0, nib} >= nib_limit)
                continue;
            if (v[4])
            begin
                held_lead = {nib, v[3:0]};
                last_addr = a;
                pairing   = EDGE_LEAD;
            end
            if (v[4:3] == 2'b01)
            begin
                if (pairing == EDGE_LEAD)
                begin
                    tt = {nib, v[2:0], 1'b0};
                    width = int'(tt) - int'(held_lead);
                    if (width > int'(width_floor))
                    begin
                        emit_edge(a, KIND_LEAD, held_lead);
                        emit_edge(a, KIND_TRAIL, tt);
                    end
                end
                last_addr = a;
                pairing   = EDGE_TRAIL;
            end
        end
        if (word_hits.size() > 0)
            word_hits[word_hits.size()-1].last = 1'b1;
    endtask

    task automatic send_word(input in_item_t w, input int typed, input out_item_t a,
                             input out_item_t b);
        @(negedge clk);
        while (take_gap())
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pair_edges(w);
        if (typed == PREDICTED)
        begin
            foreach (word_hits[i])
                hits_due.push_back(word_hits[i]);
        end
        else
        begin
            if (typed > 0)
                hits_due.push_back(a);
            if (typed > 1)
                hits_due.push_back(b);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [9:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            REG_MIN_WIDTH:     width_floor = data;
            REG_CHANNEL_COUNT: chan_limit = data[7:0];
            REG_NIBBLE_COUNT:  nib_limit = data[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [9:0] mw, input logic [9:0] cc,
                                 input logic [9:0] nc);
        write_reg(REG_MIN_WIDTH, mw);
        write_reg(REG_CHANNEL_COUNT, cc);
        write_reg(REG_NIBBLE_COUNT, nc);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Drop push and hold until every expected item is back, plus the pipeline tail.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        address_t a;
        int       pick;
        int       lead_m;
        int       trail_m;
        int       m;
        pick = $urandom_range(0, 99);
        a = pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 9) == 0)
            a = address_t'(21'($urandom));
        it.word = $urandom;
        it.word[31] = 1'b0;
        it.word[30:24] = a.channel;
        if (pick < 45)
        begin
            lead_m = $urandom_range(0, 2);
            trail_m = $urandom_range(lead_m + 1, 3);
            for (m = 0; m < 4; m++)
                it.word[m*5 +: 5] = {2'b00, 3'($urandom)};
            it.word[lead_m*5 +: 5] = {1'b1, 4'($urandom)};
            it.word[trail_m*5 +: 5] = {2'b01, 3'($urandom)};
        end
        else if (pick < 65)
        begin
            for (m = 0; m < 4; m++)
                it.word[m*5 +: 5] = {2'b00, 3'($urandom)};
            m = $urandom_range(0, 3);
            if ($urandom_range(0, 1))
                it.word[m*5 +: 5] = {1'b1, 4'($urandom)};
            else
                it.word[m*5 +: 5] = {2'b01, 3'($urandom)};
        end
        else if (pick < 75)
            it.word[31] = 1'b0;
        else if (pick < 82)
            it.word[31] = 1'b1;
        else if (pick < 88)
            it.word[19:0] = '0;
        else
            it.word = $urandom;
        it.arm = a.arm;
        it.side = a.side;
        it.keystone = a.keystone;
        it.pair = a.pair;
        it.event_start = ($urandom_range(0, 99) < 4);
        return it;
    endfunction

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge clk)
        pop <= rst_n && !take_gap();

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (hits_due.size() == 0)
            begin
                $display("%0t: expected no item got %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = hits_due.pop_front();
                report_field("hit_id", want.hit_id, result.hit_id);
                report_field("out_arm", 16'(want.out_arm), 16'(result.out_arm));
                report_field("out_side", 16'(want.out_side), 16'(result.out_side));
                report_field("out_keystone", 16'(want.out_keystone),
                             16'(result.out_keystone));
                report_field("out_pair", 16'(want.out_pair), 16'(result.out_pair));
                report_field("out_channel", 16'(want.out_channel), 16'(result.out_channel));
                report_field("edge_kind", 16'(want.edge_kind), 16'(result.edge_kind));
                report_field("edge_time", 16'(want.edge_time), 16'(result.edge_time));
                report_field("last", 16'(want.last), 16'(result.last));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int p;
        int k;
        int top;
        plan.push_back(edge_row(32'h0007_8010, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0, 2,
            hit(16'd0, 1'b0, 1'b0, 8'h00, 4'h0, 7'h00, KIND_LEAD, 10'd0, 1'b0),
            hit(16'd1, 1'b0, 1'b0, 8'h00, 4'h0, 7'h00, KIND_TRAIL, 10'd62, 1'b1)));
        plan.push_back(edge_row(32'h7FF7_801F, 1'b1, 1'b1, 8'hFF, 4'hF, 1'b1, 2,
            hit(16'd0, 1'b1, 1'b1, 8'hFF, 4'hF, 7'h7F, KIND_LEAD, 10'd975, 1'b0),
            hit(16'd1, 1'b1, 1'b1, 8'hFF, 4'hF, 7'h7F, KIND_TRAIL, 10'd1022, 1'b1)));
        plan.push_back(edge_row(32'h8000_0000, 1'b0, 1'b0, 8'h00, 4'h0, 1'b0, 0, '0, '0));
        plan.push_back(edge_row(32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 4'hF, 1'b0, 0, '0, '0));
        plan.push_back(edge_row(32'h7FF0_0000, 1'b0, 1'b1, 8'hA5, 4'h3, 1'b0, 0, '0, '0));
        plan.push_back(edge_row(32'hC123_4567, 1'b1, 1'b0, 8'h3C, 4'h5, 1'b1, 0, '0, '0));
        plan.push_back(edge_row(32'h0307_C1F0, 1'b0, 1'b1, 8'h5A, 4'hA, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0500_000F, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0520_0260, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0560_2C00, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0500_23E0, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0598_0000, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0510_000F, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0500_0010, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0630_000F, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0530_000F, 1'b1, 1'b0, 8'h11, 4'h2, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0700_0150, 1'b0, 1'b0, 8'h80, 4'h8, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0700_201B, 1'b0, 1'b0, 8'h80, 4'h8, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0806_03F0, 1'b0, 1'b1, 8'h7E, 4'h1, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0800_000F, 1'b0, 1'b1, 8'h7E, 4'h1, 1'b0, PREDICTED, '0, '0));
        plan.push_back(edge_row(32'h0007_8010, 1'b1, 1'b1, 8'h22, 4'h6, 1'b1, PREDICTED, '0, '0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_SPARE, 10'h3FF);
        @(negedge clk);
        wr_en <= 1'b0;

        foreach (plan[i])
            send_word(plan[i].stim, plan[i].typed_count, plan[i].first, plan[i].second);

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == PHASES - 1)
                load_settings(10'($urandom_range(0, 60)), 10'($urandom_range(1, 128)),
                              10'($urandom_range(16, 64)));
            else
                load_settings(10'(phase_mw[p]), 10'(phase_cc[p]), 10'(phase_nc[p]));
            top = (chan_limit == 0 || chan_limit > 8'd128) ? 127 : int'(chan_limit) - 1;
            for (k = 0; k < 4; k++)
            begin
                pool[k] = address_t'(21'($urandom));
                pool[k].channel = 7'($urandom_range(0, top));
            end
            calm = (p == 4);
            for (k = 0; k < phase_len[p]; k++)
            begin
                if (p == 1 && k == 25)
                    settle();
                send_word(random_item(), PREDICTED, '0, '0);
            end
        end
        calm = 1'b0;
        settle();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
